FILE: design/cc20_pkg.sv
// package for the chacha20 stream cipher block
// holds constants, state machine type and the controller/datapath command structs
// no dependencies
package cc20_pkg;

	localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_CNT = 3'd6;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} cc20_state_t;

	typedef struct packed {
		logic load;      // build initial state from config and counter
		logic col_round; // column half of a double round
		logic diag_round;
		logic finish;    // add initial state into keystream
	} cc20_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// one quarter round, four dependent add/xor/rotate steps on 32 bits
	function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] a1, b1, c1, d1;
		a1 = a + b;   d1 = rotl(d ^ a1, 16);
		c1 = c + d1;  b1 = rotl(b ^ c1, 12);
		a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
		c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
		qr = {a1, b1, c1, d1};
	endfunction

endpackage

FILE: design/cc20_datapath.sv
// chacha20 datapath: round words, initial state and keystream registers
// depends on cc20_pkg
module cc20_datapath (
	input  logic                   clk,
	input  cc20_pkg::cc20_cmd_t    cmd,
	input  logic [255:0]           key,
	input  logic [95:0]            nonce,
	input  logic [31:0]            counter,
	output logic [511:0]           keystream
);
	import cc20_pkg::*;

	logic [31:0] round_q [16];
	logic [31:0] init_q [16];
	logic [31:0] ks_q [16];
	logic [31:0] col_w [16];
	logic [31:0] diag_w [16];
	logic [31:0] init_w [16];

	always_comb begin
		init_w[0] = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
		for (int i = 0; i < 8; i++) begin
			init_w[4+i] = key[32*i +: 32];
		end
		init_w[12] = counter;
		init_w[13] = nonce[31:0];
		init_w[14] = nonce[63:32];
		init_w[15] = nonce[95:64];
	end

	// column round: four independent quarter rounds
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			{col_w[i], col_w[4+i], col_w[8+i], col_w[12+i]} =
				qr(round_q[i], round_q[4+i], round_q[8+i], round_q[12+i]);
		end
	end

	// diagonal round
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			{diag_w[i], diag_w[4+((i+1)%4)], diag_w[8+((i+2)%4)], diag_w[12+((i+3)%4)]} =
				qr(round_q[i], round_q[4+((i+1)%4)], round_q[8+((i+2)%4)],
					round_q[12+((i+3)%4)]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			round_q <= init_w;
			init_q  <= init_w;
		end else if (cmd.col_round) begin
			round_q <= col_w;
		end else if (cmd.diag_round) begin
			round_q <= diag_w;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 16; i++) begin
				ks_q[i] <= round_q[i] + init_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			keystream[32*i +: 32] = ks_q[i];
		end
	end

endmodule

FILE: design/cc20_ctrl.sv
// chacha20 controller: message/block sequencing, round counter and handshakes
// depends on cc20_pkg
module cc20_ctrl #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                last_byte,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic [31:0]         start_counter,
	output cc20_pkg::cc20_cmd_t cmd,
	output logic [31:0]         counter,
	output logic [5:0]          byte_pos,
	output logic                capture
);
	import cc20_pkg::*;

	localparam int unsigned HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int unsigned RW = $clog2(HALF_ROUNDS + 1);

	cc20_state_t state_q, state_d;
	logic [RW-1:0] round_cnt_q;
	logic [5:0]    pos_q;
	logic [31:0]   block_cnt_q;
	logic          active_q;
	logic          ks_ok_q;
	logic          out_valid_q;
	logic          accept;
	logic          out_free;

	assign out_free  = !out_valid_q || !out_stall;
	// a byte is taken once its block keystream is ready and the output slot frees
	assign in_stall  = !(state_q == ST_OUT && out_free);
	assign accept    = in_valid && !in_stall;
	assign capture   = accept;
	assign out_valid = out_valid_q;
	assign byte_pos  = pos_q;
	assign counter   = active_q ? block_cnt_q : start_counter;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (active_q && pos_q != 6'd0 && ks_ok_q) begin
						state_d = ST_OUT;
					end else begin
						cmd.load = 1'b1;
						state_d = ST_ROUND;
					end
				end
			end
			ST_ROUND: begin
				if (round_cnt_q[0]) begin
					cmd.diag_round = 1'b1;
				end else begin
					cmd.col_round = 1'b1;
				end
				if (round_cnt_q == RW'(HALF_ROUNDS - 1)) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (accept) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_cnt_q <= '0;
			pos_q       <= '0;
			block_cnt_q <= '0;
			active_q    <= 1'b0;
			ks_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				round_cnt_q <= '0;
				if (!active_q) begin
					block_cnt_q <= start_counter;
					active_q    <= 1'b1;
					pos_q       <= '0;
				end
			end else if (state_q == ST_ROUND) begin
				round_cnt_q <= round_cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				ks_ok_q <= 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					block_cnt_q <= block_cnt_q + 32'd1;
				end
				if (last_byte) begin
					pos_q    <= '0;
					active_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> round_cnt_q < RW'(HALF_ROUNDS))
		else $error("round counter overran");
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted byte produced no result");
	a_load_round: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_ROUND)
		else $error("load not followed by rounds");

endmodule

FILE: design/chacha20_stream_cipher_top.sv
// top level of the chacha20 stream cipher (96-bit nonce, 32-bit block counter)
// depends on cc20_pkg, cc20_ctrl, cc20_datapath
//
// Each byte is XORed with the next ChaCha20 keystream byte. The first byte of a
// 64-byte block goes through a load, DOUBLE_ROUNDS double rounds of alternating
// column and diagonal half rounds (separate units, one half round per cycle), a
// final add and an accept; other bytes only pass the controller's idle/accept
// sequence. A byte with last_byte set ends the message and the next byte reloads
// the counter from start_counter. Key and nonce are sampled at each block start.
module chacha20_stream_cipher_top #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       data_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             out_last,
	input  logic                             cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cc20_pkg::*;

	// configuration registers
	logic [255:0] key_q;
	logic [95:0]  nonce_q;
	logic [31:0]  start_cnt_q;

	cc20_cmd_t    cmd;
	logic [31:0]  counter;
	logic [5:0]   byte_pos;
	logic         capture;
	logic [511:0] keystream;
	logic [7:0]   out_byte_q;
	logic         out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			nonce_q     <= '0;
			start_cnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0:      key_q[63:0]    <= cfg_data;
				REG_KEY1:      key_q[127:64]  <= cfg_data;
				REG_KEY2:      key_q[191:128] <= cfg_data;
				REG_KEY3:      key_q[255:192] <= cfg_data;
				REG_NONCE_LO:  nonce_q[63:0]  <= cfg_data;
				REG_NONCE_HI:  nonce_q[95:64] <= cfg_data[31:0];
				REG_START_CNT: start_cnt_q    <= cfg_data[31:0];
				default: ; // unused index, ignored
			endcase
		end
	end

	cc20_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.start_counter (start_cnt_q),
		.cmd           (cmd),
		.counter       (counter),
		.byte_pos      (byte_pos),
		.capture       (capture)
	);

	cc20_datapath u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.key       (key_q),
		.nonce     (nonce_q),
		.counter   (counter),
		.keystream (keystream)
	);

	// output register, loaded with each accepted transaction
	always_ff @(posedge clk) begin
		if (capture) begin
			out_byte_q <= data_byte ^ keystream[{byte_pos, 3'b000} +: 8];
			out_last_q <= last_byte;
		end
	end

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule
